// ===== rtl/bloom_filter_four_hash_macros.svh =====
// Assertion macros for the bloom_filter_four_hash checker.
// Needs signals clk and rst_n in the scope of use.
`ifndef BLOOM_FILTER_FOUR_HASH_MACROS_SVH
`define BLOOM_FILTER_FOUR_HASH_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define BF4H_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bloom filter check failed");

// Next-cycle implication, masked while reset is asserted.
`define BF4H_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bloom filter check failed");

// Next-cycle implication that also holds across reset.
`define BF4H_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bloom filter check failed");

`endif

// ===== rtl/bf4h_pkg.sv =====
// Shared constants, codes and helper functions of the bloom filter.
// No dependencies.
`default_nettype none

package bf4h_pkg;

  localparam int MAX_TABLE_BITS = 1024;
  localparam int ADDR_W = $clog2(MAX_TABLE_BITS);
  localparam int HASH_W = ADDR_W;
  localparam int SIZE_W = ADDR_W + 1;
  localparam int CFG_W  = 11;
  localparam int BYTE_W = 8;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = CFG_W'(100);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [4:0] BASE19 = 5'd19;
  localparam logic [4:0] BASE30 = 5'd30;
  localparam logic [4:0] BASE21 = 5'd21;

  // Clamp the written size to 1 .. MAX_TABLE_BITS.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] cfg);
    logic [SIZE_W-1:0] m;
    if (cfg == '0) begin
      m = SIZE_W'(1);
    end else if (32'(cfg) > MAX_TABLE_BITS) begin
      m = SIZE_W'(MAX_TABLE_BITS);
    end else begin
      m = SIZE_W'(cfg);
    end
    return m;
  endfunction

  // Seed of hash accumulator i (0, 1, 7, 3) reduced mod m.
  function automatic logic [HASH_W-1:0] start_sum(input logic [1:0] which,
                                                  input logic [SIZE_W-1:0] m);
    logic [SIZE_W-1:0] v;
    case (which)
      2'd0:    v = SIZE_W'(0);
      2'd1:    v = SIZE_W'(1);
      2'd2:    v = SIZE_W'(7);
      default: v = SIZE_W'(3);
    endcase
    for (int i = 0; i < 7; i++) begin
      if (v >= m) begin
        v = v - m;
      end
    end
    return HASH_W'(v);
  endfunction

  // One mod m.
  function automatic logic [HASH_W-1:0] one_mod(input logic [SIZE_W-1:0] m);
    return (m == SIZE_W'(1)) ? HASH_W'(0) : HASH_W'(1);
  endfunction

  // Power base of power accumulator i.
  function automatic logic [4:0] base_of(input logic [1:0] which);
    logic [4:0] b;
    case (which)
      2'd0:    b = BASE19;
      2'd1:    b = BASE30;
      default: b = BASE21;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bf4h_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bf4h_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bloom_filter_four_hash.sv =====
// Top level of the four-hash bloom filter: sequencer, shared multiply-reduce
// step unit and hash registers. Depends on bf4h_pkg and bf4h_ram.
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+---------------------------
//   input   | in_cmd, in_key_byte, in_last_byte            | transfer when start & !busy
//   result  | out_maybe_present                            | out_valid, one-cycle strobe
//   config  | cfg_wdata (table size)                       | write when cfg_we
//
// Per byte: a non-final key byte keeps busy high through four 8-step
// multiply-accumulates, each closed by an add step, then three 5-step power
// updates; no new byte is taken until busy drops. A final byte runs only the
// four multiply-accumulates, then sets its four bits (insert) or reads and
// tests them (search); the search result strobes the cycle after the last test.
// Hashing runs on the single shared step unit, one multiplier bit a cycle.
// Reset: a clearing pass walks all MAX_TABLE_BITS (1024) bits of the filter
// RAM one bit a cycle, holding busy high; config writes are taken meanwhile.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module bloom_filter_four_hash (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_cmd,
  input  wire logic [bf4h_pkg::BYTE_W-1:0]   in_key_byte,
  input  wire logic                          in_last_byte,
  output logic                               out_valid,
  output logic                               out_maybe_present,
  input  wire logic                          cfg_we,
  input  wire logic [bf4h_pkg::CFG_W-1:0]    cfg_wdata
);

  import bf4h_pkg::*;

  localparam int EXT_W = HASH_W + 2;
  localparam logic [2:0] JOB_LAST_SUM = 3'd3;
  localparam logic [2:0] JOB_LAST_POW = 3'd6;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_WR,
    ST_RD,
    ST_CHK
  } state_t;

  state_t              state_r,  state_nxt;
  logic [ADDR_W-1:0]   clr_r,    clr_nxt;
  logic [SIZE_W-1:0]   size_r,   size_nxt;
  logic [HASH_W-1:0]   sum_r [4];
  logic [HASH_W-1:0]   sum_nxt [4];
  logic [HASH_W-1:0]   pow_r [3];
  logic [HASH_W-1:0]   pow_nxt [3];
  logic [HASH_W-1:0]   acc_r,    acc_nxt;
  logic [BYTE_W-1:0]   mul_r,    mul_nxt;
  logic [2:0]          cnt_r,    cnt_nxt;
  logic [2:0]          job_r,    job_nxt;
  logic [1:0]          idx_r,    idx_nxt;
  logic                cmd_r,    cmd_nxt;
  logic [BYTE_W-1:0]   byte_r,   byte_nxt;
  logic                last_r,   last_nxt;
  logic                hit_r,    hit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r,   out_hit_nxt;

  // shared step unit
  logic [HASH_W-1:0]   one_m;
  logic [HASH_W-1:0]   p_sel;
  logic [EXT_W-1:0]    add_a, add_b, add_sum, red1, m_ext;
  logic [HASH_W-1:0]   step_res;

  // sequencer helpers
  logic                adv;
  logic                do_init;
  logic [SIZE_W-1:0]   init_size;
  logic [2:0]          job_n;
  logic [1:0]          pidx;

  // filter RAM
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic                ram_wdata;
  logic                ram_rdata;

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_maybe_present = out_hit_r;

  assign one_m = one_mod(size_r);
  assign m_ext = EXT_W'(size_r);

  // Pick the multiplicand: 1 mod m for the plain sum, else the matching power.
  always_comb begin
    case (job_r) inside
      3'd1, 3'd4: p_sel = pow_r[0];
      3'd2, 3'd5: p_sel = pow_r[1];
      3'd3, 3'd6: p_sel = pow_r[2];
      default:    p_sel = one_m;
    endcase
  end

  // Horner step r = 2r + bit*p, or the final accumulate sum + r; both stay
  // below 3m, so two conditional subtracts bring them back under m.
  always_comb begin
    if (state_r == ST_ADD) begin
      add_a = EXT_W'(sum_r[job_r[1:0]]);
      add_b = EXT_W'(acc_r);
    end else begin
      add_a = {1'b0, acc_r, 1'b0};
      add_b = mul_r[BYTE_W-1] ? EXT_W'(p_sel) : '0;
    end
    add_sum  = add_a + add_b;
    red1     = (add_sum >= m_ext) ? (add_sum - m_ext) : add_sum;
    step_res = (red1 >= m_ext) ? HASH_W'(red1 - m_ext) : HASH_W'(red1);
  end

  assign ram_raddr = sum_r[idx_r];
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : sum_r[idx_r];
  assign ram_we    = (state_r == ST_CLEAR) || (state_r == ST_WR);
  assign ram_wdata = (state_r == ST_WR);

  bf4h_ram #(
    .WIDTH (1),
    .DEPTH (MAX_TABLE_BITS)
  ) u_filter (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    size_nxt      = size_r;
    sum_nxt       = sum_r;
    pow_nxt       = pow_r;
    acc_nxt       = acc_r;
    mul_nxt       = mul_r;
    cnt_nxt       = cnt_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    adv           = 1'b0;
    do_init       = 1'b0;
    init_size     = size_r;
    job_n         = job_r + 3'd1;
    pidx          = 2'(job_r - 3'd4);

    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(MAX_TABLE_BITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_cmd;
          byte_nxt  = in_key_byte;
          last_nxt  = in_last_byte;
          job_nxt   = 3'd0;
          acc_nxt   = '0;
          mul_nxt   = in_key_byte;
          cnt_nxt   = 3'd7;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt = step_res;
        mul_nxt = mul_r << 1;
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          if (job_r <= JOB_LAST_SUM) begin
            state_nxt = ST_ADD;
          end else begin
            pow_nxt[pidx] = step_res;
            adv           = 1'b1;
          end
        end
      end
      ST_ADD: begin
        sum_nxt[job_r[1:0]] = step_res;
        adv                 = 1'b1;
      end
      ST_WR: begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          do_init   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        hit_nxt = hit_r & ram_rdata;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd3) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r & ram_rdata;
          do_init       = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Advance to the next job, or finish the byte.
    if (adv) begin
      if (job_r == JOB_LAST_SUM && last_r) begin
        idx_nxt   = 2'd0;
        hit_nxt   = 1'b1;
        state_nxt = (cmd_r == CMD_INSERT) ? ST_WR : ST_RD;
      end else if (job_r == JOB_LAST_POW) begin
        state_nxt = ST_IDLE;
      end else begin
        job_nxt   = job_n;
        acc_nxt   = '0;
        state_nxt = ST_MUL;
        if (job_n <= JOB_LAST_SUM) begin
          mul_nxt = byte_r;
          cnt_nxt = 3'd7;
        end else begin
          mul_nxt = {base_of(2'(job_n - 3'd4)), 3'b000};
          cnt_nxt = 3'd4;
        end
      end
    end

    // A size write drops any partial key and restarts under the new size.
    if (cfg_we) begin
      init_size = eff_size(cfg_wdata);
      size_nxt  = init_size;
      do_init   = 1'b1;
    end

    if (do_init) begin
      for (int i = 0; i < 4; i++) begin
        sum_nxt[i] = start_sum(2'(i), init_size);
      end
      for (int i = 0; i < 3; i++) begin
        pow_nxt[i] = one_mod(init_size);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      size_r      <= eff_size(TABLE_SIZE_RESET);
      for (int i = 0; i < 4; i++) begin
        sum_r[i] <= start_sum(2'(i), eff_size(TABLE_SIZE_RESET));
      end
      for (int i = 0; i < 3; i++) begin
        pow_r[i] <= one_mod(eff_size(TABLE_SIZE_RESET));
      end
      job_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      size_r      <= size_nxt;
      sum_r       <= sum_nxt;
      pow_r       <= pow_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    mul_r     <= mul_nxt;
    cmd_r     <= cmd_nxt;
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    hit_r     <= hit_nxt;
    out_hit_r <= out_hit_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/bf4h_checker.sv =====
// Port-level checker for bloom_filter_four_hash, bound to the top level.
// Depends on bloom_filter_four_hash_macros.svh.
`default_nettype none

`include "bloom_filter_four_hash_macros.svh"

module bf4h_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // A transfer always starts work.
  `BF4H_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Results are single-cycle strobes.
  `BF4H_ASSERT_NEXT(a_strobe_one, out_valid, !out_valid)
  // A result only appears as the block drops busy at the end of a search.
  `BF4H_ASSERT_SAME(a_result_end, out_valid, !busy && $past(busy))
  // Reset always starts the clearing pass.
  `BF4H_ASSERT_NEXT_ALWAYS(a_reset_clear, !rst_n, busy && !out_valid)

endmodule

bind bloom_filter_four_hash bf4h_checker u_bf4h_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire

// ===== test/bloom_filter_four_hash_tb.sv =====
// Self-checking testbench for bloom_filter_four_hash: keys byte by byte, searches checked
// against a shadow filter kept in a small scoreboard class.
// Depends on bf4h_pkg and the bloom_filter_four_hash RTL only.

module bloom_filter_four_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bf4h_pkg::*;

  // Hold-off before a size write: long enough for a final or non-final byte
  // to finish, and an insert produces no result to wait for.
  localparam int unsigned SETTLE_CYCLES = 64;
  // Slowest run: ~1330 bytes, each with its busy window and idle gaps, size
  // writes and the clearing pass after reset; taken several times over.
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASE_ITEMS   = 128;
  localparam int unsigned MAX_KEY_BYTES = 6;
  localparam int unsigned SEED_BASE19   = 1;
  localparam int unsigned SEED_BASE30   = 7;
  localparam int unsigned SEED_BASE21   = 3;
  localparam int unsigned PRINT_CAP     = 40;

  typedef struct {
    logic [8*MAX_KEY_BYTES-1:0] key_bytes;
    int unsigned                key_len;
  } key_t;

  // Shadow copy of the filter: bit array, size register and the four
  // running hashes. Search results are queued in order of acceptance.
  class filter_scoreboard;
    bit                 filter_bits[MAX_TABLE_BITS];
    logic [CFG_W-1:0]   table_size;
    int unsigned        sum_plain, sum19, sum30, sum21;
    int unsigned        pow19, pow30, pow21;
    bit                 expected_presence[$];
    int unsigned        mismatches, results_checked, hits;

    function new();
      foreach (filter_bits[i]) filter_bits[i] = 1'b0;
      table_size      = TABLE_SIZE_RESET;
      mismatches      = 0;
      results_checked = 0;
      hits            = 0;
      restart_key();
    endfunction

    // Clamp the size register to the usable range 1 .. MAX_TABLE_BITS.
    function int unsigned modulus();
      if (table_size == '0) return 1;
      if (table_size > MAX_TABLE_BITS) return MAX_TABLE_BITS;
      return table_size;
    endfunction

    function void restart_key();
      int unsigned m;
      m         = modulus();
      sum_plain = 0;
      sum19     = SEED_BASE19 % m;
      sum30     = SEED_BASE30 % m;
      sum21     = SEED_BASE21 % m;
      pow19     = 1 % m;
      pow30     = 1 % m;
      pow21     = 1 % m;
    endfunction

    // A size write drops any partial key; stored bits survive.
    function void write_size(logic [CFG_W-1:0] value);
      table_size = value;
      restart_key();
    endfunction

    function int unsigned pending();
      return expected_presence.size();
    endfunction

    // Fold one accepted byte into the hashes; on the final byte either set
    // the four bits or queue the search outcome.
    function void absorb_byte(logic cmd, logic [BYTE_W-1:0] kb, logic last);
      int unsigned m;
      int unsigned h[4];
      bit          all_set;
      m         = modulus();
      sum_plain = (sum_plain + kb) % m;
      sum19     = (sum19 + (kb * pow19) % m) % m;
      sum30     = (sum30 + (kb * pow30) % m) % m;
      sum21     = (sum21 + (kb * pow21) % m) % m;
      pow19     = (pow19 * BASE19) % m;
      pow30     = (pow30 * BASE30) % m;
      pow21     = (pow21 * BASE21) % m;
      if (!last) return;
      h[0] = sum_plain;
      h[1] = sum19;
      h[2] = sum30;
      h[3] = sum21;
      restart_key();
      if (cmd == CMD_INSERT) begin
        foreach (h[i]) filter_bits[h[i]] = 1'b1;
      end else begin
        all_set = 1'b1;
        foreach (h[i]) all_set &= filter_bits[h[i]];
        expected_presence.insert(expected_presence.size(), all_set);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      // Keep the log short on a badly broken build; keep counting.
      if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_presence(logic got);
      bit want;
      if (expected_presence.size() == 0) begin
        report_mismatch($sformatf("result %0b with no search outstanding", got));
        return;
      end
      want = expected_presence.pop_front();
      results_checked++;
      if (got) hits++;
      if (got !== want)
        report_mismatch($sformatf("maybe_present got %b, want %0b", got, want));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_cmd;
  logic [BYTE_W-1:0]   in_key_byte;
  logic                in_last_byte;
  logic                out_valid;
  logic                out_maybe_present;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;

  filter_scoreboard    board;
  key_t                stored_keys[$];
  bit                  idle_on;
  int unsigned         bytes_sent;
  int unsigned         keys_sent;
  int unsigned         size_writes;
  int unsigned         cycle_count;

  bloom_filter_four_hash u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_key_byte       (in_key_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_maybe_present (out_maybe_present),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d searches outstanding",
               cycle_count, board.pending());
      $display("bloom_filter_four_hash_tb NOT OK");
      $finish;
    end
  end

  // Results cannot be held off: take each strobe at the edge ending it.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_presence(out_maybe_present);
  end

  // Offer one byte and hold it until the block takes it (start high, busy
  // low at the edge). Idle gaps are chains of bursts, so the moment start
  // rises lands anywhere within the block's busy window.
  task automatic send_byte(input logic cmd, input logic [BYTE_W-1:0] kb,
                           input logic last);
    int unsigned bursts;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      bursts = $urandom_range(1, 4);
      start       <= 1'b0;
      in_key_byte <= BYTE_W'($urandom);
      in_cmd      <= 1'($urandom);
      repeat (bursts) repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_key_byte  <= kb;
    in_last_byte <= last;
    do @(posedge clk); while (busy);
    board.absorb_byte(cmd, kb, last);
    bytes_sent++;
  endtask

  // Intermediate bytes mostly carry the key's own command; the rest get a
  // random one, which the block must ignore.
  task automatic send_key(input logic cmd, input key_t k);
    for (int unsigned i = 0; i < k.key_len; i++) begin
      send_byte((i == k.key_len - 1 || $urandom_range(0, 4) != 0) ? cmd : 1'($urandom),
                k.key_bytes[8*i +: 8], i == k.key_len - 1);
    end
    keys_sent++;
  endtask

  // Write the size only with the block idle: drain searches, let any
  // insert or partial byte finish, then wait for busy low.
  task automatic write_table_size(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.write_size(value);
    size_writes++;
  endtask

  function automatic key_t make_key(input logic [8*MAX_KEY_BYTES-1:0] kbytes,
                                    input int unsigned len);
    key_t k;
    k.key_bytes = kbytes;
    k.key_len   = len;
    return k;
  endfunction

  // Mostly short keys, some up to the full length.
  function automatic key_t random_key();
    key_t k;
    k.key_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3)
                                           : $urandom_range(4, MAX_KEY_BYTES);
    for (int i = 0; i < MAX_KEY_BYTES; i++) k.key_bytes[8*i +: 8] = BYTE_W'($urandom);
    return k;
  endfunction

  // One size setting: mostly inserts and searches of known and fresh keys;
  // now and then abandon a key halfway by rewriting the size.
  task automatic run_phase(input logic [CFG_W-1:0] size, input bit with_idle);
    key_t        k;
    int unsigned first;
    int unsigned pick;
    write_table_size(size);
    first = bytes_sent;
    while (bytes_sent - first < PHASE_ITEMS) begin
      idle_on = with_idle && ($urandom_range(0, 2) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 40 || stored_keys.size() == 0) begin
        k = random_key();
        stored_keys.insert(stored_keys.size(), k);
        if (stored_keys.size() > 48) void'(stored_keys.pop_front());
        send_key(CMD_INSERT, k);
      end else if (pick < 75) begin
        send_key(CMD_SEARCH, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      end else if (pick < 95) begin
        send_key(CMD_SEARCH, random_key());
      end else begin
        k = random_key();
        for (int unsigned i = 0; i + 1 < k.key_len || i == 0; i++)
          send_byte(1'($urandom), k.key_bytes[8*i +: 8], 1'b0);
        write_table_size(size);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_sizes[10];
    board        = new();
    cycle_count  = 0;
    bytes_sent   = 0;
    keys_sent    = 0;
    size_writes  = 0;
    idle_on      = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = CMD_INSERT;
    in_key_byte  = '0;
    in_last_byte = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 100: byte extremes first.
    send_key(CMD_INSERT, make_key(48'h00, 1));
    send_key(CMD_SEARCH, make_key(48'h00, 1));
    send_key(CMD_SEARCH, make_key(48'hFF, 1));
    send_key(CMD_INSERT, make_key(48'hFF, 1));
    send_key(CMD_SEARCH, make_key(48'hFF, 1));
    send_key(CMD_INSERT, make_key(48'hFF_AB_12, 3));
    send_key(CMD_SEARCH, make_key(48'hFF_AB_12, 3));

    // Mixed commands within one key: only the final byte's command counts.
    send_byte(CMD_SEARCH, 8'h33, 1'b0);
    send_byte(CMD_INSERT, 8'h44, 1'b1);
    send_byte(CMD_INSERT, 8'h33, 1'b0);
    send_byte(CMD_SEARCH, 8'h44, 1'b1);

    // Size write in the middle of a key: drop the partial byte.
    send_byte(CMD_INSERT, 8'h5A, 1'b0);
    write_table_size(CFG_W'(1024));
    send_key(CMD_SEARCH, make_key(48'h44, 1));

    // Size zero acts as one: every hash lands on bit 0.
    write_table_size('0);
    send_key(CMD_INSERT, make_key(48'h09, 1));
    send_key(CMD_SEARCH, make_key(48'hC8, 1));

    // Oversized value saturates at the full table.
    write_table_size('1);
    send_key(CMD_SEARCH, make_key(48'h01, 1));
    send_key(CMD_INSERT, make_key(48'h01, 1));
    send_key(CMD_SEARCH, make_key(48'h01, 1));

    // Back down to one bit: the stale bit 0 still answers.
    write_table_size(CFG_W'(1));
    send_key(CMD_SEARCH, make_key(48'h77, 1));

    // Random phases across the size range; the last one runs without gaps.
    phase_sizes = '{CFG_W'(1024), '1, '0, CFG_W'(1), CFG_W'(1025), CFG_W'(100),
                    CFG_W'(7), CFG_W'($urandom_range(2, 1023)),
                    CFG_W'($urandom_range(0, 2047)), CFG_W'(13)};
    foreach (phase_sizes[p]) run_phase(phase_sizes[p], p != $size(phase_sizes) - 1);

    // Drain: wait for outstanding searches, then let the last insert settle.
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d key bytes in %0d keys, %0d search results checked (%0d hits)",
             bytes_sent, keys_sent, board.results_checked, board.hits);
    $display("%0d table size writes incl. 0, 1, 1024, 2047 and mid-key; %0d mismatches",
             size_writes, board.mismatches);
    if (board.mismatches == 0) begin
      $display("bloom_filter_four_hash_tb OK");
    end else begin
      $display("bloom_filter_four_hash_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bf4h_pkg.sv
rtl/bf4h_ram.sv
rtl/bloom_filter_four_hash.sv
rtl/bf4h_checker.sv
test/bloom_filter_four_hash_tb.sv
